@@ hw/rtl/proq_pkg.sv @@
package proq_pkg;

  // Widths of the request and result fields
  localparam int FUNC_BITS   = 2;
  localparam int POLICY_BITS = 2;
  localparam int STATUS_BITS = 2;
  localparam int FIELD_PAGE_BITS = 16;
  localparam int FIELD_OCC_BITS  = 5;

  // Request functions
  typedef enum logic [FUNC_BITS-1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_REFER  = 2'd1,
    FUNC_REMOVE = 2'd2,
    FUNC_NOP    = 2'd3
  } func_t;

  // Replacement policies (code 3 falls back to FIFO)
  localparam logic [POLICY_BITS-1:0] POLICY_FIFO = 2'd0;
  localparam logic [POLICY_BITS-1:0] POLICY_LRU  = 2'd1;
  localparam logic [POLICY_BITS-1:0] POLICY_LFU  = 2'd2;

  // Result status codes
  localparam logic [STATUS_BITS-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_BITS-1:0] STATUS_MISS  = 2'd1;
  localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd2;
  localparam logic [STATUS_BITS-1:0] STATUS_EMPTY = 2'd3;

  // Which cell leaves its place during a shift
  typedef enum logic [1:0] {
    RSEL_NONE  = 2'd0,  // nothing leaves
    RSEL_HIT   = 2'd1,  // the first cell that matched
    RSEL_FREE  = 2'd2,  // the first empty cell (plain insert)
    RSEL_FRONT = 2'd3   // the head cell
  } rsel_t;

  // Control broadcast from the sequencer to every cell
  typedef struct packed {
    logic  search;  // compare cycle: mark first match
    logic  apply;   // shift cycle: commit next values
    rsel_t r_sel;
    logic  k_en;    // an entry is written somewhere
    logic  g_en;    // place by use count (LFU)
  } proq_ctl_t;

endpackage

@@ hw/rtl/proq_cell.sv @@
module proq_cell #(
  parameter int IDX        = 0,
  parameter int PAGE_BITS  = 16,
  parameter int COUNT_BITS = 16,
  parameter int OCC_BITS   = 5
) (
  input  logic                  clk,
  input  logic                  rst,
  input  proq_pkg::proq_ctl_t   ctl,
  input  logic [OCC_BITS-1:0]   occ,
  input  logic [PAGE_BITS-1:0]  key_page,
  input  logic [COUNT_BITS-1:0] key_count,
  input  logic [PAGE_BITS-1:0]  left_page,
  input  logic [COUNT_BITS-1:0] left_count,
  input  logic [PAGE_BITS-1:0]  right_page,
  input  logic [COUNT_BITS-1:0] right_count,
  input  logic                  right_is_k,
  input  logic                  r_seen_in,
  input  logic                  k_seen_in,
  input  logic                  ka_in,
  output logic                  r_seen_out,
  output logic                  k_seen_out,
  output logic                  ka_out,
  output logic                  is_k,
  output logic [COUNT_BITS-1:0] hit_count,
  output logic [PAGE_BITS-1:0]  page,
  output logic [COUNT_BITS-1:0] count,
  output logic [PAGE_BITS-1:0]  page_next
);
  import proq_pkg::*;

  localparam logic [OCC_BITS-1:0] SLOT = OCC_BITS'(IDX);

  typedef enum logic [1:0] {
    SRC_KEEP  = 2'd0,
    SRC_LEFT  = 2'd1,
    SRC_RIGHT = 2'd2,
    SRC_NEW   = 2'd3
  } src_t;

  logic                  valid;
  logic                  mark;
  logic                  r_cand;
  logic                  is_r;
  logic                  g;
  logic                  k_cand;
  logic                  ka;
  src_t                  src;
  logic [COUNT_BITS-1:0] count_next;

  // Slots below the occupancy hold pages
  assign valid = (SLOT < occ);

  // Candidate for the leaving cell
  always_comb begin
    if (ctl.search) begin
      r_cand = valid && (page == key_page);
    end else begin
      case (ctl.r_sel)
        RSEL_HIT:   r_cand = mark;
        RSEL_FREE:  r_cand = !valid;
        RSEL_FRONT: r_cand = 1'b1;
        default:    r_cand = 1'b0;
      endcase
    end
  end

  assign is_r       = r_cand && !r_seen_in;
  assign r_seen_out = r_seen_in || r_cand;
  assign hit_count  = is_r ? count : '0;

  // Insertion point: first live entry with a larger count, else first free slot
  assign g          = ctl.g_en && valid && (count > key_count) && !is_r;
  assign k_cand     = ctl.k_en && (g || !valid);
  assign is_k       = k_cand && !k_seen_in;
  assign k_seen_out = k_seen_in || k_cand;

  // Insertion point lies ahead of the leaving cell
  assign ka     = ka_in || (is_k && !r_seen_in);
  assign ka_out = ka;

  // Source of this cell's next entry
  always_comb begin
    if (ka) begin
      if (is_k) begin
        src = SRC_NEW;
      end else if (!r_seen_in) begin
        src = SRC_LEFT;
      end else begin
        src = SRC_KEEP;
      end
    end else if (r_seen_in || is_r) begin
      if (right_is_k) begin
        src = SRC_NEW;
      end else if (!(k_seen_in || is_k)) begin
        src = SRC_RIGHT;
      end else begin
        src = SRC_KEEP;
      end
    end else begin
      src = SRC_KEEP;
    end
  end

  always_comb begin
    case (src)
      SRC_LEFT: begin
        page_next  = left_page;
        count_next = left_count;
      end
      SRC_RIGHT: begin
        page_next  = right_page;
        count_next = right_count;
      end
      SRC_NEW: begin
        page_next  = key_page;
        count_next = key_count;
      end
      default: begin
        page_next  = page;
        count_next = count;
      end
    endcase
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (ctl.apply) begin
      page  <= page_next;
      count <= count_next;
    end
  end

  // First-match mark from the compare cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      mark <= 1'b0;
    end else if (ctl.search) begin
      mark <= is_r;
    end
  end

endmodule

@@ hw/rtl/page_replacement_order_queue_unit.sv @@
// Page replacement order queue: an ordered row of FRAMES cells holding resident
// pages, the head cell being the next victim, ordered FIFO, LRU or LFU as set
// by the policy register (write it only while the block is idle). Each request
// runs as a compare cycle, in which every cell matches the page against its
// own entry at once, and then a shift cycle, in which every cell takes its
// neighbour's entry, the new entry or keeps its own. The result lands in an
// output register; the next request is taken during the shift cycle when that
// register is free or being emptied; no request is taken during a compare cycle.
// Misses, inserts into a full table and removals from an empty one are flagged
// in status and leave the table as is.
module page_replacement_order_queue_unit #(
  parameter int FRAMES     = 16,
  parameter int PAGE_BITS  = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [proq_pkg::POLICY_BITS-1:0]      cfg_wdata,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [proq_pkg::FUNC_BITS-1:0]        func,
  input  logic [proq_pkg::FIELD_PAGE_BITS-1:0]  page_number,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [proq_pkg::STATUS_BITS-1:0]      status,
  output logic [proq_pkg::FIELD_PAGE_BITS-1:0]  removed_page,
  output logic                                  front_valid,
  output logic [proq_pkg::FIELD_PAGE_BITS-1:0]  front_page,
  output logic [proq_pkg::FIELD_OCC_BITS-1:0]   occupancy
);
  import proq_pkg::*;

  localparam int OCC_BITS = $clog2(FRAMES + 1);
  localparam logic [OCC_BITS-1:0]   OCC_FULL  = OCC_BITS'(FRAMES);
  localparam logic [OCC_BITS-1:0]   OCC_ONE   = OCC_BITS'(1);
  localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_APPLY  = 3'b100
  } state_t;

  state_t                 state;
  state_t                 state_next;
  logic [POLICY_BITS-1:0] policy;
  func_t                  req_func;
  logic [PAGE_BITS-1:0]   req_key;
  logic [OCC_BITS-1:0]    occ;
  logic [OCC_BITS-1:0]    occ_next;
  logic                   hit_any;
  logic [COUNT_BITS-1:0]  cnt_key;
  logic [COUNT_BITS-1:0]  cnt_key_next;
  logic [COUNT_BITS-1:0]  hit_cnt;
  logic [STATUS_BITS-1:0] status_next;
  proq_ctl_t              ctl;
  logic                   out_free;
  logic                   apply_go;
  logic                   accept;
  logic [31:0]            key_wide;
  logic [31:0]            removed_wide;
  logic [31:0]            front_wide;
  logic [31:0]            occ_wide;
  logic [PAGE_BITS-1:0]   removed_val;
  logic [PAGE_BITS-1:0]   front_val;

  logic [PAGE_BITS-1:0]  cell_page      [FRAMES];
  logic [COUNT_BITS-1:0] cell_count     [FRAMES];
  logic [PAGE_BITS-1:0]  cell_page_next [FRAMES];
  logic [COUNT_BITS-1:0] cell_hit_count [FRAMES];
  logic                  cell_is_k      [FRAMES+1];
  logic                  r_chain        [FRAMES+1];
  logic                  k_chain        [FRAMES+1];
  logic                  ka_chain       [FRAMES+1];

  // Handshake
  assign out_free = !out_valid || !out_stall;
  assign apply_go = (state == ST_APPLY) && out_free;
  assign in_stall = !((state == ST_IDLE) || apply_go);
  assign accept   = in_valid && !in_stall;

  assign key_wide = 32'(page_number);

  // Row of cells
  assign r_chain[0]  = 1'b0;
  assign k_chain[0]  = 1'b0;
  assign ka_chain[0] = 1'b0;
  assign cell_is_k[FRAMES] = ctl.k_en && !k_chain[FRAMES];

  for (genvar i = 0; i < FRAMES; i++) begin : g_cell
    logic [PAGE_BITS-1:0]  lp;
    logic [COUNT_BITS-1:0] lc;
    logic [PAGE_BITS-1:0]  rp;
    logic [COUNT_BITS-1:0] rc;

    if (i == 0) begin : g_head
      assign lp = '0;
      assign lc = '0;
    end else begin : g_mid
      assign lp = cell_page[i-1];
      assign lc = cell_count[i-1];
    end

    if (i == FRAMES - 1) begin : g_tail
      assign rp = '0;
      assign rc = '0;
    end else begin : g_body
      assign rp = cell_page[i+1];
      assign rc = cell_count[i+1];
    end

    proq_cell #(
      .IDX        (i),
      .PAGE_BITS  (PAGE_BITS),
      .COUNT_BITS (COUNT_BITS),
      .OCC_BITS   (OCC_BITS)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .occ         (occ),
      .key_page    (req_key),
      .key_count   (cnt_key),
      .left_page   (lp),
      .left_count  (lc),
      .right_page  (rp),
      .right_count (rc),
      .right_is_k  (cell_is_k[i+1]),
      .r_seen_in   (r_chain[i]),
      .k_seen_in   (k_chain[i]),
      .ka_in       (ka_chain[i]),
      .r_seen_out  (r_chain[i+1]),
      .k_seen_out  (k_chain[i+1]),
      .ka_out      (ka_chain[i+1]),
      .is_k        (cell_is_k[i]),
      .hit_count   (cell_hit_count[i]),
      .page        (cell_page[i]),
      .count       (cell_count[i]),
      .page_next   (cell_page_next[i])
    );
  end

  // Count of the first match (one-hot, so an OR picks it)
  always_comb begin
    hit_cnt = '0;
    for (int i = 0; i < FRAMES; i++) begin
      hit_cnt = hit_cnt | cell_hit_count[i];
    end
  end

  // References count only under LFU; LRU carries the count unchanged
  always_comb begin
    if (req_func == FUNC_REFER) begin
      if (policy == POLICY_LFU && hit_cnt != COUNT_MAX) begin
        cnt_key_next = hit_cnt + COUNT_ONE;
      end else begin
        cnt_key_next = hit_cnt;
      end
    end else begin
      cnt_key_next = COUNT_ONE;
    end
  end

  // Decode of the shift
  always_comb begin
    ctl.search  = (state == ST_SEARCH);
    ctl.apply   = apply_go;
    ctl.r_sel   = RSEL_NONE;
    ctl.k_en    = 1'b0;
    ctl.g_en    = 1'b0;
    status_next = STATUS_OK;
    occ_next    = occ;
    case (req_func)
      FUNC_INSERT: begin
        if (occ == OCC_FULL) begin
          status_next = STATUS_FULL;
        end else begin
          ctl.r_sel = RSEL_FREE;
          ctl.k_en  = 1'b1;
          ctl.g_en  = (policy == POLICY_LFU);
          occ_next  = occ + OCC_ONE;
        end
      end
      FUNC_REFER: begin
        if (!hit_any) begin
          status_next = STATUS_MISS;
        end else if (policy == POLICY_LRU || policy == POLICY_LFU) begin
          ctl.r_sel = RSEL_HIT;
          ctl.k_en  = 1'b1;
          ctl.g_en  = (policy == POLICY_LFU);
        end
      end
      FUNC_REMOVE: begin
        if (occ == '0) begin
          status_next = STATUS_EMPTY;
        end else begin
          ctl.r_sel = RSEL_FRONT;
          occ_next  = occ - OCC_ONE;
        end
      end
      default: begin
      end
    endcase
  end

  assign removed_val  = (req_func == FUNC_REMOVE && occ != '0) ? cell_page[0] : '0;
  assign front_val    = (occ_next != '0) ? cell_page_next[0] : '0;
  assign removed_wide = 32'(removed_val);
  assign front_wide   = 32'(front_val);
  assign occ_wide     = 32'(occ_next);

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (accept) state_next = ST_SEARCH;
      ST_SEARCH: state_next = ST_APPLY;
      ST_APPLY: begin
        if (apply_go) begin
          state_next = accept ? ST_SEARCH : ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Policy register
  always_ff @(posedge clk) begin
    if (rst) begin
      policy <= POLICY_FIFO;
    end else if (cfg_we) begin
      policy <= cfg_wdata;
    end
  end

  // Request capture
  always_ff @(posedge clk) begin
    if (rst) begin
      req_func <= FUNC_NOP;
    end else if (accept) begin
      req_func <= func_t'(func);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_key <= key_wide[PAGE_BITS-1:0];
    end
  end

  // Compare-cycle results
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_any <= 1'b0;
    end else if (ctl.search) begin
      hit_any <= r_chain[FRAMES];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.search) begin
      cnt_key <= cnt_key_next;
    end
  end

  // Occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else if (apply_go) begin
      occ <= occ_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (apply_go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (apply_go) begin
      status       <= status_next;
      removed_page <= removed_wide[FIELD_PAGE_BITS-1:0];
      front_valid  <= (occ_next != '0);
      front_page   <= front_wide[FIELD_PAGE_BITS-1:0];
      occupancy    <= occ_wide[FIELD_OCC_BITS-1:0];
    end
  end

  // Checks
  a_accept_search: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_SEARCH)
    else $error("accepted request did not start a compare cycle");

  a_search_apply: assert property (@(posedge clk) disable iff (rst)
    state == ST_SEARCH |=> state == ST_APPLY)
    else $error("compare cycle not followed by shift cycle");

  a_occ_hold: assert property (@(posedge clk) disable iff (rst)
    !apply_go |=> $stable(occ))
    else $error("occupancy changed outside a shift cycle");

  a_full_flag: assert property (@(posedge clk) disable iff (rst)
    apply_go && req_func == FUNC_INSERT && occ == OCC_FULL
      |=> out_valid && status == STATUS_FULL && $stable(occ))
    else $error("insert into full table not flagged");

endmodule
